/* hdl/skcm_pkg.sv */
`default_nettype none

package skcm_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LEN_W      = $clog2(LIST_DEPTH + 1);

    localparam int KEY_W      = 64;
    localparam int COUNT_W    = 31;
    localparam int ENTRY_W    = KEY_W + COUNT_W;
    localparam int DATA_W     = 96;
    localparam int CMD_W      = 2;

    localparam logic [CMD_W-1:0] CMD_APPEND_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN      = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef logic [LEN_W-1:0] len_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [KEY_W-1:0]   key;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_CMP   = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

endpackage

`default_nettype wire

/* hdl/sorted_key_count_merge.sv */
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tuser: cmd; s_tdata: in_key, in_count
// m_*       out        m_tvalid/m_tready  m_tdata: out_key, out_count; m_tlast: out_last
//
// An append leaves the block idle, so it stays ready for the next command.
// A run of k merged pairs steps through the accepting cycle, a fetch state for
// the first registered read of the list memories, then a compare state and an
// output state per pair through the single key compare / count adder.
// A run with both lists empty keeps the block idle and emits nothing.
// The input is not ready while a run is in progress; an output stall holds the
// pair and the sequencer in place. Reset empties both lists.

module sorted_key_count_merge (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [skcm_pkg::DATA_W-1:0]  s_tdata,   // in_key [63:0], in_count [94:64]
    input  wire  [skcm_pkg::CMD_W-1:0]   s_tuser,   // cmd [1:0]
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [skcm_pkg::DATA_W-1:0]  m_tdata,   // out_key [63:0], out_count [94:64]
    output logic                         m_tlast
);

    skcm_pkg::state_t state_reg, state_next;
    skcm_pkg::len_t   a_len_reg, a_len_next;
    skcm_pkg::len_t   b_len_reg, b_len_next;
    skcm_pkg::len_t   ia_reg, ia_next;
    skcm_pkg::len_t   ib_reg, ib_next;

    skcm_pkg::entry_t mem_a [skcm_pkg::LIST_DEPTH];
    skcm_pkg::entry_t mem_b [skcm_pkg::LIST_DEPTH];
    skcm_pkg::entry_t a_rd_reg, b_rd_reg;

    logic [skcm_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [skcm_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                         last_reg, last_next;

    logic                         in_fire, out_fire;
    logic                         wr_a, wr_b;
    logic                         a_more, b_more;
    logic [skcm_pkg::COUNT_W:0]   sum;
    logic                         keys_eq, a_lt_b;
    skcm_pkg::entry_t             in_entry;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign s_tready = (state_reg == skcm_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == skcm_pkg::ST_OUT);
    assign m_tdata  = {1'b0, count_reg, key_reg};
    assign m_tlast  = last_reg;

    assign in_entry.key   = s_tdata[skcm_pkg::KEY_W-1:0];
    assign in_entry.count = s_tdata[skcm_pkg::ENTRY_W-1:skcm_pkg::KEY_W];

    assign wr_a = in_fire && (s_tuser == skcm_pkg::CMD_APPEND_A)
                  && (a_len_reg < skcm_pkg::LEN_W'(skcm_pkg::LIST_DEPTH));
    assign wr_b = in_fire && (s_tuser == skcm_pkg::CMD_APPEND_B)
                  && (b_len_reg < skcm_pkg::LEN_W'(skcm_pkg::LIST_DEPTH));

    // List memories: one write port for appends, one registered read port
    // addressed by the merge index.
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[a_len_reg[skcm_pkg::ADDR_W-1:0]] <= in_entry;
        end
        a_rd_reg <= mem_a[ia_reg[skcm_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            mem_b[b_len_reg[skcm_pkg::ADDR_W-1:0]] <= in_entry;
        end
        b_rd_reg <= mem_b[ib_reg[skcm_pkg::ADDR_W-1:0]];
    end

    // Shared compare and saturating add unit.
    assign a_more  = (ia_reg < a_len_reg);
    assign b_more  = (ib_reg < b_len_reg);
    assign keys_eq = (a_rd_reg.key == b_rd_reg.key);
    assign a_lt_b  = (a_rd_reg.key < b_rd_reg.key);
    assign sum     = {1'b0, a_rd_reg.count} + {1'b0, b_rd_reg.count};

    always_comb
    begin
        state_next = state_reg;
        a_len_next = a_len_reg;
        b_len_next = b_len_reg;
        ia_next    = ia_reg;
        ib_next    = ib_reg;
        key_next   = key_reg;
        count_next = count_reg;
        last_next  = last_reg;

        unique case (state_reg)
            skcm_pkg::ST_IDLE:
            begin
                if (wr_a)
                begin
                    a_len_next = a_len_reg + 1'b1;
                end
                if (wr_b)
                begin
                    b_len_next = b_len_reg + 1'b1;
                end
                if (in_fire && (s_tuser == skcm_pkg::CMD_RUN))
                begin
                    ia_next = '0;
                    ib_next = '0;
                    if ((a_len_reg != '0) || (b_len_reg != '0))
                    begin
                        state_next = skcm_pkg::ST_FETCH;
                    end
                end
            end
            skcm_pkg::ST_FETCH:
            begin
                state_next = skcm_pkg::ST_CMP;
            end
            skcm_pkg::ST_CMP:
            begin
                priority if (!a_more)
                begin
                    key_next   = b_rd_reg.key;
                    count_next = b_rd_reg.count;
                    ib_next    = ib_reg + 1'b1;
                end
                else if (!b_more)
                begin
                    key_next   = a_rd_reg.key;
                    count_next = a_rd_reg.count;
                    ia_next    = ia_reg + 1'b1;
                end
                else if (keys_eq)
                begin
                    key_next   = a_rd_reg.key;
                    count_next = sum[skcm_pkg::COUNT_W] ? skcm_pkg::COUNT_MAX
                                                        : sum[skcm_pkg::COUNT_W-1:0];
                    ia_next    = ia_reg + 1'b1;
                    ib_next    = ib_reg + 1'b1;
                end
                else if (a_lt_b)
                begin
                    key_next   = a_rd_reg.key;
                    count_next = a_rd_reg.count;
                    ia_next    = ia_reg + 1'b1;
                end
                else
                begin
                    key_next   = b_rd_reg.key;
                    count_next = b_rd_reg.count;
                    ib_next    = ib_reg + 1'b1;
                end
                last_next  = (ia_next >= a_len_reg) && (ib_next >= b_len_reg);
                state_next = skcm_pkg::ST_OUT;
            end
            skcm_pkg::ST_OUT:
            begin
                // The read port already follows the advanced indices, so the
                // next compare can start right after the handshake.
                if (out_fire)
                begin
                    if (last_reg)
                    begin
                        a_len_next = '0;
                        b_len_next = '0;
                        ia_next    = '0;
                        ib_next    = '0;
                        state_next = skcm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = skcm_pkg::ST_CMP;
                    end
                end
            end
            default:
            begin
                state_next = skcm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skcm_pkg::ST_IDLE;
            a_len_reg <= '0;
            b_len_reg <= '0;
            ia_reg    <= '0;
            ib_reg    <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            a_len_reg <= a_len_next;
            b_len_reg <= b_len_next;
            ia_reg    <= ia_next;
            ib_reg    <= ib_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        count_reg <= count_next;
    end

    // A compare only happens while some list still has pairs to emit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == skcm_pkg::ST_CMP) |-> (a_more || b_more))
        else $error("compare with both lists drained");

    // The final pair of a run returns the block to idle with both lists empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && m_tlast) |=> (s_tready && (a_len_reg == '0) && (b_len_reg == '0)))
        else $error("lists not emptied after run");

    // A run on two empty lists emits nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (s_tuser == skcm_pkg::CMD_RUN) && (a_len_reg == '0)
         && (b_len_reg == '0)) |=> (s_tready && !m_tvalid))
        else $error("empty run produced activity");

    // Indices never run past the list lengths.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ia_reg <= a_len_reg) && (ib_reg <= b_len_reg)
        && (a_len_reg <= skcm_pkg::LEN_W'(skcm_pkg::LIST_DEPTH)))
        else $error("merge index beyond list length");

endmodule

`default_nettype wire
